// File: rtl/ffwq_pkg.sv
// ---------------------------------------------------------------------------
// ffwq_pkg
// Shared codes, widths and controller/datapath command type for the
// first-fit waitlist queue.
// ---------------------------------------------------------------------------
package ffwq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;

    localparam int TYPE_W   = 2;
    localparam int KEY_W    = 32;
    localparam int SIZE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int FILL_W   = 5;
    localparam int IN_W     = 48;
    localparam int OUT_W    = 48;

    localparam logic [TYPE_W-1:0] REQ_ADD   = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_SEAT  = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_CLEAR = 2'd2;
    localparam logic [TYPE_W-1:0] REQ_RSVD  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUP     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SEATED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOFIT   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd6;

    typedef struct packed {
        logic capture;  // latch request, register key match and fit vectors
        logic commit;   // update cells and load the result register
    } t_dp_cmd;

endpackage

// File: rtl/first_fit_waitlist_queue_core.sv
// ---------------------------------------------------------------------------
// first_fit_waitlist_queue_core
// Ordered waitlist with unique keys: add, seat first fitting entry, clear.
// ---------------------------------------------------------------------------
// Each request beat but type 3 gives exactly one result beat (type 3 is
// taken and dropped). The accept cycle compares the key and capacity against
// every occupied cell in parallel and registers the match and fit vectors;
// the evaluate step then resolves the oldest fitting entry, compacts the
// cells and loads the result register. The block accepts its next request
// once that result is registered, even if it is still waiting downstream;
// a stalled result holds the evaluate step until the result register frees up.
module first_fit_waitlist_queue_core
    import ffwq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // [31:0] entry_key, [39:32] entry_size, [47:40] capacity
    input  logic [IN_W-1:0]     s_axis_tdata,
    // [1:0] req_type
    input  logic [TYPE_W-1:0]   s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [31:0] out_key, [39:32] out_size, [44:40] fill_count, [47:45] zero
    output logic [OUT_W-1:0]    m_axis_tdata,
    // [2:0] status
    output logic [STATUS_W-1:0] m_axis_tuser
);

    t_dp_cmd             cmd;
    logic [KEY_W-1:0]    out_key;
    logic [SIZE_W-1:0]   out_size;
    logic [FILL_W-1:0]   fill_count;

    ffwq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_valid  (s_axis_tvalid),
        .o_s_ready  (s_axis_tready),
        .i_req_type (s_axis_tuser),
        .o_m_valid  (m_axis_tvalid),
        .i_m_ready  (m_axis_tready),
        .o_cmd      (cmd)
    );

    ffwq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_req_type   (s_axis_tuser),
        .i_entry_key  (s_axis_tdata[31:0]),
        .i_entry_size (s_axis_tdata[39:32]),
        .i_capacity   (s_axis_tdata[47:40]),
        .o_status     (m_axis_tuser),
        .o_out_key    (out_key),
        .o_out_size   (out_size),
        .o_fill_count (fill_count)
    );

    assign m_axis_tdata = {3'b000, fill_count, out_size, out_key};

endmodule

// File: rtl/ffwq_ctrl.sv
// ---------------------------------------------------------------------------
// ffwq_ctrl
// Request sequencer: accepts one beat, runs the evaluate step, and owns the
// valid flag of the result register.
// ---------------------------------------------------------------------------
module ffwq_ctrl
    import ffwq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_valid,
    output logic              o_s_ready,
    input  logic [TYPE_W-1:0] i_req_type,
    output logic              o_m_valid,
    input  logic              i_m_ready,
    output t_dp_cmd           o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EVAL = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic accept;
    logic commit;

    assign o_s_ready = (r_state == S_IDLE);
    assign accept    = i_s_valid && o_s_ready;
    assign commit    = (r_state == S_EVAL) && (!r_out_valid || i_m_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                // drop the reserved request type without a result
                if (accept && (i_req_type != REQ_RSVD)) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (commit) begin
            n_out_valid = 1'b1;
        end else if (i_m_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_valid     = r_out_valid;
    assign o_cmd.capture = accept;
    assign o_cmd.commit  = commit;

`ifndef SYNTHESIS
    a_commit_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> r_out_valid)
        else $error("result register not loaded after commit");
    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_ready) |=> r_out_valid)
        else $error("pending result dropped");
    a_eval_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_req_type != REQ_RSVD)) |=> (r_state == S_EVAL))
        else $error("accepted request not evaluated");
`endif

endmodule

// File: rtl/ffwq_dp.sv
// ---------------------------------------------------------------------------
// ffwq_dp
// Queue datapath: a row of compacting cells, parallel key and fit compares,
// first-fit pick and removal, and the result register.
// ---------------------------------------------------------------------------
module ffwq_dp
    import ffwq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  logic [TYPE_W-1:0]   i_req_type,
    input  logic [KEY_W-1:0]    i_entry_key,
    input  logic [SIZE_W-1:0]   i_entry_size,
    input  logic [SIZE_W-1:0]   i_capacity,
    output logic [STATUS_W-1:0] o_status,
    output logic [KEY_W-1:0]    o_out_key,
    output logic [SIZE_W-1:0]   o_out_size,
    output logic [FILL_W-1:0]   o_fill_count
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

    logic [KEY_W-1:0]       r_key  [QUEUE_DEPTH];
    logic [SIZE_W-1:0]      r_size [QUEUE_DEPTH];
    logic [CW-1:0]          r_count, n_count;

    logic [TYPE_W-1:0]      r_type;
    logic [KEY_W-1:0]       r_in_key;
    logic [SIZE_W-1:0]      r_in_size;
    logic                   r_dup;
    logic [QUEUE_DEPTH-1:0] r_fit;

    logic [QUEUE_DEPTH-1:0] match;
    logic [QUEUE_DEPTH-1:0] fit;
    logic [QUEUE_DEPTH-1:0] pick;
    logic [QUEUE_DEPTH-1:0] below;
    logic [KEY_W-1:0]       hit_key;
    logic [SIZE_W-1:0]      hit_size;
    logic                   do_add;
    logic                   do_seat;
    logic [STATUS_W-1:0]    n_status;

    logic [STATUS_W-1:0]    r_o_status;
    logic [KEY_W-1:0]       r_o_key;
    logic [SIZE_W-1:0]      r_o_size;
    logic [FILL_W-1:0]      r_o_fill;

    // compare the incoming request against every occupied cell
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            match[i] = (CW'(i) < r_count) && (r_key[i] == i_entry_key);
            fit[i]   = (CW'(i) < r_count) && (r_size[i] <= i_capacity);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_type    <= i_req_type;
            r_in_key  <= i_entry_key;
            r_in_size <= i_entry_size;
            r_dup     <= |match;
            r_fit     <= fit;
        end
    end

    // oldest fitting entry, and the mask of cells in front of it
    assign pick  = r_fit & (~r_fit + QUEUE_DEPTH'(1));
    assign below = pick - QUEUE_DEPTH'(1);

    always_comb begin
        hit_key  = '0;
        hit_size = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            hit_key  = hit_key  | ({KEY_W{pick[i]}}  & r_key[i]);
            hit_size = hit_size | ({SIZE_W{pick[i]}} & r_size[i]);
        end
    end

    always_comb begin
        do_add   = 1'b0;
        do_seat  = 1'b0;
        n_count  = r_count;
        n_status = ST_CLEARED;
        case (r_type)
            REQ_ADD: begin
                if (r_dup) begin
                    n_status = ST_DUP;
                end else if (r_count == FULL_COUNT) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_ADDED;
                    do_add   = 1'b1;
                    n_count  = r_count + CW'(1);
                end
            end
            REQ_SEAT: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else if (r_fit == '0) begin
                    n_status = ST_NOFIT;
                end else begin
                    n_status = ST_SEATED;
                    do_seat  = 1'b1;
                    n_count  = r_count - CW'(1);
                end
            end
            REQ_CLEAR: begin
                n_status = ST_CLEARED;
                n_count  = '0;
            end
            default: begin
                n_status = ST_CLEARED;
                n_count  = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.commit) begin
            r_count <= n_count;
        end
    end

    // each cell takes the new entry, closes the gap behind the pick, or holds
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                if (do_add && (CW'(i) == r_count)) begin
                    r_key[i]  <= r_in_key;
                    r_size[i] <= r_in_size;
                end else if (do_seat && !below[i] && (i < QUEUE_DEPTH - 1)) begin
                    r_key[i]  <= r_key[(i + 1) % QUEUE_DEPTH];
                    r_size[i] <= r_size[(i + 1) % QUEUE_DEPTH];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_o_status <= n_status;
            r_o_key    <= do_seat ? hit_key : '0;
            r_o_size   <= do_seat ? hit_size : '0;
            r_o_fill   <= FILL_W'(n_count);
        end
    end

    assign o_status     = r_o_status;
    assign o_out_key    = r_o_key;
    assign o_out_size   = r_o_size;
    assign o_fill_count = r_o_fill;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("entry count above queue depth");
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.capture && i_cmd.commit))
        else $error("capture and commit in the same cycle");
    a_seat_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && do_seat) |=> (r_count == $past(r_count) - CW'(1)))
        else $error("seat did not remove one entry");
    a_pick_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && do_seat) |-> $onehot(pick))
        else $error("first-fit pick not one-hot");
`endif

endmodule
